// ----- hdl/mi3_pkg.sv -----
// ----------------------------------------------------------------------------
// mi3_pkg: shared types, constants and helpers for the 3x3 inverse core
// Holds the unrounded float format handed to the rounding stages, the
// operand selection tables and two small bit-level helper functions.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    // Unrounded result: the MSB of sig has weight 2^(exp - 127).
    typedef struct packed {
        logic               sgn;
        logic signed [11:0] exp;
        logic [51:0]        sig;
        logic               spec;
        logic [31:0]        spec_val;
    } mi3_raw_t;

    // Entry index is row * 3 + column. The first six products feed the
    // determinant, then two products for each cofactor in row-major order.
    localparam logic [3:0] M1_LHS [24] = '{
        4'd0, 4'd1, 4'd2, 4'd0, 4'd1, 4'd2,
        4'd4, 4'd7, 4'd7, 4'd1, 4'd1, 4'd2, 4'd5, 4'd8, 4'd8, 4'd2,
        4'd2, 4'd0, 4'd3, 4'd6, 4'd6, 4'd0, 4'd0, 4'd1};
    localparam logic [3:0] M1_RHS [24] = '{
        4'd4, 4'd5, 4'd3, 4'd5, 4'd3, 4'd4,
        4'd8, 4'd5, 4'd2, 4'd8, 4'd5, 4'd4, 4'd6, 4'd3, 4'd0, 4'd6,
        4'd3, 4'd5, 4'd7, 4'd4, 4'd1, 4'd7, 4'd4, 4'd3};
    localparam logic [3:0] DET_THIRD [6] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6};

    function automatic logic [5:0] lzc52(input logic [51:0] x);
        logic [5:0] n;
        logic       found;
        n     = 6'd52;
        found = 1'b0;
        for (int i = 51; i >= 0; i--) begin
            if (!found && x[i]) begin
                n     = 6'(51 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Right shift that folds every bit shifted out into the LSB.
    function automatic logic [51:0] jam_shr(input logic [51:0] x, input logic [6:0] amt);
        logic [51:0] mask;
        logic [51:0] r;
        mask = '0;
        if (amt >= 7'd52) begin
            r = {51'b0, |x};
        end
        else begin
            mask = ~({52{1'b1}} << amt);
            r    = x >> amt;
            r[0] = r[0] | (|(x & mask));
        end
        return r;
    endfunction

endpackage

// ----- hdl/matrix_inverse_3x3_core.sv -----
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core: pipelined 3x3 binary32 matrix inverse
// Inverts a 3x3 float matrix by the adjugate over the determinant, with
// every operation rounded to nearest even in a fixed order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_*       in         tdata: a_r0c0 .. a_r2c2, 32 bits each, a_r0c0 lowest
//  m_*       out        tdata: inv_r0c0 .. inv_r2c2, inv_r0c0 lowest
//                       tuser: singular
//
//  A matrix is accepted every cycle unless every stage holds one.
//  The depth is set by the products and cofactors, the chain of five dependent
//  adds that build the determinant and the sixteen-stage divider.
//  Reset clears only the stage valid bits; the datapath registers have no reset.
//  A stage holds only when it is full and the stage ahead holds, so bubbles
//  close up and the input keeps taking transfers while a result waits.
//
module matrix_inverse_3x3_core
    import mi3_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,   // a_r0c0, a_r0c1, ..., a_r2c2 from bit 0 up
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata,   // inv_r0c0, inv_r0c1, ..., inv_r2c2 from bit 0 up
    output logic         m_tuser    // singular
);

    localparam int unsigned NSTG = 38;

    // Stage map: products 1-3, triple products and cofactors 4-6, the five
    // determinant adds 7-21, division 22-37, output register 38.
    logic [NSTG:1]    v_reg;
    logic [NSTG:1]    v_src;
    logic [NSTG:1]    en;

    logic [8:0][31:0] a_in;
    logic [8:0][31:0] a_pipe_reg [1:37];
    logic [31:0]      p1 [24];
    logic [5:0][31:0] tri_w;
    logic [8:0][31:0] cof_w;
    logic [5:0][31:0] tri_pipe_reg [7:18];
    logic [8:0][31:0] cof_pipe_reg [7:21];
    logic [31:0]      sum_w [1:5];
    logic [31:0]      det;
    logic             det_zero;
    logic             z_pipe_reg [22:37];
    logic [8:0][31:0] q_w;
    logic [8:0][31:0] out_data_next, out_data_reg;
    logic             out_user_reg;
    logic             out_nan_ok;

    assign a_in = s_tdata;

    // Ready chain: a stage may load when it is empty or the next stage loads.
    always_comb
    begin
        en[NSTG] = !v_reg[NSTG] || m_tready;
        for (int i = NSTG - 1; i >= 1; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign v_src    = {v_reg[NSTG-1:1], s_tvalid};
    assign s_tready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 1; i <= NSTG; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_src[i];
                end
            end
        end
    end

    // The input matrix travels along for the singular case.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            a_pipe_reg[1] <= s_tdata;
        end
        for (int i = 2; i <= 37; i++)
        begin
            if (en[i])
            begin
                a_pipe_reg[i] <= a_pipe_reg[i-1];
            end
        end
    end

    genvar g;
    generate
        // First products: six pair products for the determinant and the
        // eighteen products of the cofactors.
        for (g = 0; g < 24; g++)
        begin : g_mul1
            mi3_fmul u_mul (
                .clk (clk),
                .en  (en[3:1]),
                .a   (a_in[M1_LHS[g]]),
                .b   (a_in[M1_RHS[g]]),
                .res (p1[g])
            );
        end

        for (g = 0; g < 6; g++)
        begin : g_mul2
            mi3_fmul u_mul (
                .clk (clk),
                .en  (en[6:4]),
                .a   (p1[g]),
                .b   (a_pipe_reg[3][DET_THIRD[g]]),
                .res (tri_w[g])
            );
        end

        for (g = 0; g < 9; g++)
        begin : g_cof
            mi3_fadd u_sub (
                .clk (clk),
                .en  (en[6:4]),
                .sub (1'b1),
                .a   (p1[6+2*g]),
                .b   (p1[7+2*g]),
                .res (cof_w[g])
            );
        end

        // Determinant: two adds of the positive terms, then three subtracts,
        // strictly left to right.
        for (g = 1; g <= 5; g++)
        begin : g_det
            if (g == 1)
            begin : g_first
                mi3_fadd u_add (
                    .clk (clk),
                    .en  (en[9:7]),
                    .sub (1'b0),
                    .a   (tri_w[0]),
                    .b   (tri_w[1]),
                    .res (sum_w[1])
                );
            end
            else
            begin : g_next
                mi3_fadd u_add (
                    .clk (clk),
                    .en  (en[3*g+6:3*g+4]),
                    .sub (g >= 3),
                    .a   (sum_w[g-1]),
                    .b   (tri_pipe_reg[3*g+3][g]),
                    .res (sum_w[g])
                );
            end
        end

        for (g = 0; g < 9; g++)
        begin : g_div
            mi3_fdiv u_div (
                .clk (clk),
                .en  (en[37:22]),
                .x   (cof_pipe_reg[21][g]),
                .y   (det),
                .res (q_w[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            tri_pipe_reg[7] <= tri_w;
            cof_pipe_reg[7] <= cof_w;
        end
        for (int i = 8; i <= 18; i++)
        begin
            if (en[i])
            begin
                tri_pipe_reg[i] <= tri_pipe_reg[i-1];
            end
        end
        for (int i = 8; i <= 21; i++)
        begin
            if (en[i])
            begin
                cof_pipe_reg[i] <= cof_pipe_reg[i-1];
            end
        end
    end

    assign det      = sum_w[5];
    assign det_zero = (det[30:0] == 31'd0);

    always_ff @(posedge clk)
    begin
        if (en[22])
        begin
            z_pipe_reg[22] <= det_zero;
        end
        for (int i = 23; i <= 37; i++)
        begin
            if (en[i])
            begin
                z_pipe_reg[i] <= z_pipe_reg[i-1];
            end
        end
    end

    // A singular matrix comes back as it went in; otherwise every NaN
    // quotient leaves as the canonical quiet NaN.
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            if (z_pipe_reg[37])
                out_data_next[i] = a_pipe_reg[37][i];
            else if ((q_w[i][30:23] == 8'hFF) && (q_w[i][22:0] != 23'd0))
                out_data_next[i] = QNAN;
            else
                out_data_next[i] = q_w[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTG])
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= z_pipe_reg[37];
        end
    end

    assign m_tvalid = v_reg[NSTG];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        out_nan_ok = 1'b1;
        for (int i = 0; i < 9; i++)
        begin
            if ((out_data_reg[i][30:23] == 8'hFF) && (out_data_reg[i][22:0] != 23'd0)
                && (out_data_reg[i] != QNAN))
            begin
                out_nan_ok = 1'b0;
            end
        end
    end

    // Input back-pressure only when every stage holds an item.
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&v_reg))
        else $error("input stalled while the pipeline has a free stage");

    // An accepted transfer must occupy the first stage.
    a_take_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v_reg[1])
        else $error("accepted transfer did not enter the pipeline");

    // Non-singular results carry only the canonical NaN.
    a_canon_nan: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> out_nan_ok)
        else $error("non-canonical NaN in a non-singular result");

endmodule

// ----- hdl/mi3_round.sv -----
// ----------------------------------------------------------------------------
// mi3_round: two-stage normalize and round to binary32
// Stage one finds the leading one and normalizes; stage two denormalizes
// for tiny results, rounds to nearest even and packs.
// ----------------------------------------------------------------------------
module mi3_round
    import mi3_pkg::*;
(
    input  logic        clk,
    input  logic [1:0]  en,
    input  mi3_raw_t    raw,
    output logic [31:0] res
);

    typedef struct packed {
        logic               sgn;
        logic signed [11:0] exp;
        logic [51:0]        sig;
        logic               zero;
        logic               spec;
        logic [31:0]        spec_val;
    } nrm_t;

    nrm_t               nrm_next, nrm_reg;
    logic [5:0]         lz;
    logic signed [11:0] e_n, sh, e2;
    logic               subn, g, st, up;
    logic [6:0]         amt;
    logic [51:0]        dsig;
    logic [23:0]        m;
    logic [24:0]        mr;
    logic [31:0]        res_next, res_reg;

    always_comb
    begin
        lz                = lzc52(raw.sig);
        nrm_next.sgn      = raw.sgn;
        nrm_next.exp      = raw.exp - $signed({6'b0, lz});
        nrm_next.sig      = raw.sig << lz;
        nrm_next.zero     = (raw.sig == '0);
        nrm_next.spec     = raw.spec;
        nrm_next.spec_val = raw.spec_val;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            nrm_reg <= nrm_next;
        end
    end

    always_comb
    begin
        e_n  = nrm_reg.exp;
        sh   = 12'sd1 - e_n;
        subn = (e_n < 12'sd1);
        amt  = subn ? ((sh > 12'sd63) ? 7'd63 : sh[6:0]) : 7'd0;
        dsig = jam_shr(nrm_reg.sig, amt);
        m    = dsig[51:28];
        g    = dsig[27];
        st   = |dsig[26:0];
        up   = g & (st | m[0]);
        mr   = {1'b0, m} + {24'b0, up};
        e2   = mr[24] ? e_n + 12'sd1 : e_n;
        if (nrm_reg.spec)
            res_next = nrm_reg.spec_val;
        else if (nrm_reg.zero)
            res_next = {nrm_reg.sgn, 31'b0};
        else if (subn)
            res_next = {nrm_reg.sgn, 7'b0, mr[23], mr[22:0]};
        else if (e2 >= 12'sd255)
            res_next = {nrm_reg.sgn, 8'hFF, 23'b0};
        else
            res_next = {nrm_reg.sgn, e2[7:0], mr[24] ? mr[23:1] : mr[22:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- hdl/mi3_fmul.sv -----
// ----------------------------------------------------------------------------
// mi3_fmul: three-stage binary32 multiplier
// Multiplies the significands in the first stage, then rounds in two.
// ----------------------------------------------------------------------------
module mi3_fmul
    import mi3_pkg::*;
(
    input  logic        clk,
    input  logic [2:0]  en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] res
);

    mi3_raw_t    raw_next, raw_reg;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] prod;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;

    always_comb
    begin
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma     = {a[30:23] != 8'd0, a[22:0]};
        mb     = {b[30:23] != 8'd0, b[22:0]};
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        sgn    = a[31] ^ b[31];
        prod   = ma * mb;

        raw_next.sgn      = sgn;
        raw_next.exp      = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd126;
        raw_next.sig      = {prod, 4'b0};
        raw_next.spec     = 1'b1;
        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
            raw_next.spec_val = QNAN;
        else if (a_inf || b_inf)
            raw_next.spec_val = {sgn, 8'hFF, 23'b0};
        else if (a_zero || b_zero)
            raw_next.spec_val = {sgn, 31'b0};
        else
        begin
            raw_next.spec     = 1'b0;
            raw_next.spec_val = QNAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            raw_reg <= raw_next;
        end
    end

    mi3_round u_rnd (
        .clk (clk),
        .en  (en[2:1]),
        .raw (raw_reg),
        .res (res)
    );

endmodule

// ----- hdl/mi3_fadd.sv -----
// ----------------------------------------------------------------------------
// mi3_fadd: three-stage binary32 adder and subtractor
// Aligns and adds in the first stage, then rounds in two. The sub input
// flips the sign of b.
// ----------------------------------------------------------------------------
module mi3_fadd
    import mi3_pkg::*;
(
    input  logic        clk,
    input  logic [2:0]  en,
    input  logic        sub,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] res
);

    mi3_raw_t    raw_next, raw_reg;
    logic        sa, sb, swap, s_big, eff_sub, zsgn;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [31:0] big, sml;
    logic [7:0]  e_big, e_sml, d;
    logic [23:0] m_big, m_sml;
    logic [51:0] al_big, al_sml;
    logic [52:0] sum;

    always_comb
    begin
        sa      = a[31];
        sb      = b[31] ^ sub;
        a_nan   = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan   = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf   = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf   = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero  = (a[30:0] == 31'd0);
        b_zero  = (b[30:0] == 31'd0);
        swap    = (b[30:0] > a[30:0]);
        big     = swap ? b : a;
        sml     = swap ? a : b;
        s_big   = swap ? sb : sa;
        eff_sub = sa ^ sb;
        e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_sml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        m_big   = {big[30:23] != 8'd0, big[22:0]};
        m_sml   = {sml[30:23] != 8'd0, sml[22:0]};
        d       = e_big - e_sml;
        al_big  = {m_big, 28'b0};
        al_sml  = jam_shr({m_sml, 28'b0}, (d > 8'd63) ? 7'd63 : d[6:0]);
        sum     = eff_sub ? {1'b0, al_big} - {1'b0, al_sml}
                          : {1'b0, al_big} + {1'b0, al_sml};
        // An exact zero is +0 unless a and b, its sign flipped by sub, are both -0.
        zsgn    = (a_zero && b_zero) ? (sa & sb) : 1'b0;

        raw_next.sgn  = s_big;
        raw_next.exp  = $signed({4'b0, e_big}) + 12'sd1;
        raw_next.sig  = {sum[52:2], sum[1] | sum[0]};
        raw_next.spec = 1'b1;
        if (a_nan || b_nan || (a_inf && b_inf && eff_sub))
            raw_next.spec_val = QNAN;
        else if (a_inf)
            raw_next.spec_val = {sa, 8'hFF, 23'b0};
        else if (b_inf)
            raw_next.spec_val = {sb, 8'hFF, 23'b0};
        else if (sum == 53'd0)
            raw_next.spec_val = {zsgn, 31'b0};
        else
        begin
            raw_next.spec     = 1'b0;
            raw_next.spec_val = QNAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            raw_reg <= raw_next;
        end
    end

    mi3_round u_rnd (
        .clk (clk),
        .en  (en[2:1]),
        .raw (raw_reg),
        .res (res)
    );

endmodule

// ----- hdl/mi3_fdiv.sv -----
// ----------------------------------------------------------------------------
// mi3_fdiv: sixteen-stage pipelined binary32 divider
// One unpack stage, thirteen restoring stages of two quotient bits each,
// and two rounding stages.
// ----------------------------------------------------------------------------
module mi3_fdiv
    import mi3_pkg::*;
(
    input  logic        clk,
    input  logic [15:0] en,
    input  logic [31:0] x,
    input  logic [31:0] y,
    output logic [31:0] res
);

    localparam int unsigned ITER = 13;

    typedef struct packed {
        logic               sgn;
        logic signed [11:0] exp;
        logic [23:0]        dvs;
        logic [25:0]        rem;
        logic [25:0]        quo;
        logic               spec;
        logic [31:0]        spec_val;
    } fdv_t;

    fdv_t        it_next [ITER+1];
    fdv_t        it_reg  [ITER+1];
    mi3_raw_t    raw;
    logic [7:0]  ex, ey;
    logic [23:0] mx, my, mxn, myn;
    logic [5:0]  lzx, lzy;
    logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero, sgn;

    always_comb
    begin
        ex     = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey     = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx     = {x[30:23] != 8'd0, x[22:0]};
        my     = {y[30:23] != 8'd0, y[22:0]};
        lzx    = lzc52({mx, 28'b0});
        lzy    = lzc52({my, 28'b0});
        mxn    = mx << lzx[4:0];
        myn    = my << lzy[4:0];
        x_nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        y_nan  = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        x_inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        y_inf  = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
        x_zero = (x[30:0] == 31'd0);
        y_zero = (y[30:0] == 31'd0);
        sgn    = x[31] ^ y[31];

        it_next[0].sgn  = sgn;
        it_next[0].exp  = ($signed({4'b0, ex}) - $signed({6'b0, lzx}))
                        - ($signed({4'b0, ey}) - $signed({6'b0, lzy})) + 12'sd127;
        it_next[0].dvs  = myn;
        it_next[0].rem  = {2'b0, mxn};
        it_next[0].quo  = '0;
        it_next[0].spec = 1'b1;
        if (x_nan || y_nan || (x_zero && y_zero) || (x_inf && y_inf))
            it_next[0].spec_val = QNAN;
        else if (x_inf || y_zero)
            it_next[0].spec_val = {sgn, 8'hFF, 23'b0};
        else if (x_zero || y_inf)
            it_next[0].spec_val = {sgn, 31'b0};
        else
        begin
            it_next[0].spec     = 1'b0;
            it_next[0].spec_val = QNAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            it_reg[0] <= it_next[0];
        end
    end

    genvar k;
    generate
        for (k = 1; k <= ITER; k++)
        begin : g_iter
            logic [25:0] r1, r2;
            logic        q1, q2;

            always_comb
            begin
                q1 = (it_reg[k-1].rem >= {2'b0, it_reg[k-1].dvs});
                r1 = q1 ? it_reg[k-1].rem - {2'b0, it_reg[k-1].dvs} : it_reg[k-1].rem;
                r1 = {r1[24:0], 1'b0};
                q2 = (r1 >= {2'b0, it_reg[k-1].dvs});
                r2 = q2 ? r1 - {2'b0, it_reg[k-1].dvs} : r1;
                r2 = {r2[24:0], 1'b0};
                it_next[k]     = it_reg[k-1];
                it_next[k].rem = r2;
                it_next[k].quo = {it_reg[k-1].quo[23:0], q1, q2};
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    it_reg[k] <= it_next[k];
                end
            end
        end
    endgenerate

    always_comb
    begin
        raw.sgn      = it_reg[ITER].sgn;
        raw.exp      = it_reg[ITER].exp;
        raw.sig      = {it_reg[ITER].quo, it_reg[ITER].rem != 26'd0, 25'b0};
        raw.spec     = it_reg[ITER].spec;
        raw.spec_val = it_reg[ITER].spec_val;
    end

    mi3_round u_rnd (
        .clk (clk),
        .en  (en[15:14]),
        .raw (raw),
        .res (res)
    );

endmodule

// ----- tb/sv/matrix_inverse_3x3_checker.sv -----
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_checker: scoreboard for the 3x3 inverse core
// Predicts every inverse from the accepted input matrices with its own
// bit-exact binary32 arithmetic and compares the output transfers in order.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [287:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [287:0] m_tdata,
    input  logic         m_tuser,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef struct {
        logic [287:0] inv;
        logic         singular;
    } inverse_t;

    inverse_t inverse_queue[$];

    function automatic real pow2(input int k);
        logic [10:0] e;
        e = 11'(k + 1023);
        return $bitstoreal({1'b0, e, 52'b0});
    endfunction

    // Exact widening of a binary32 pattern to a double.
    function automatic real f32_to_real(input logic [31:0] b);
        real v;
        if (b[30:23] == 8'hFF) begin
            if (b[22:0] != 0)
                return $bitstoreal(64'h7FF8_0000_0000_0000);
            v = $bitstoreal(64'h7FF0_0000_0000_0000);
        end
        else if (b[30:23] == 8'h00)
            v = real'(b[22:0]) * pow2(-149);
        else
            v = real'({1'b1, b[22:0]}) * pow2(int'(b[30:23]) - 150);
        return b[31] ? -v : v;
    endfunction

    // Round a double to binary32, nearest even, subnormals kept.
    function automatic logic [31:0] real_to_f32(input real x);
        logic [63:0]       d;
        longint unsigned   sig;
        longint unsigned   q;
        longint unsigned   rem;
        longint unsigned   half;
        int                e;
        int                sh;
        logic [31:0]       r;
        d = $realtobits(x);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? CANON_NAN : {d[63], 31'h7F80_0000};
        if (d[62:52] == 11'h000)
            return {d[63], 31'b0};
        e   = int'(d[62:52]) - 1023;
        sig = {11'b0, 1'b1, d[51:0]};
        if (e > 127)
            return {d[63], 31'h7F80_0000};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh >= 63)
            return {d[63], 31'b0};
        q    = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 1;
        if (e >= -126)
            r = 32'((longint'(e + 127) << 23) + q - 64'd8388608);
        else
            r = 32'(q);
        if (r[30:23] == 8'hFF)
            r[22:0] = '0;
        r[31] = d[63];
        return r;
    endfunction

    // Each binary32 operation is done in double, exact for products, then rounded once.
    function automatic logic [31:0] fmul(input logic [31:0] x, input logic [31:0] y);
        return real_to_f32(f32_to_real(x) * f32_to_real(y));
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] x, input logic [31:0] y);
        return real_to_f32(f32_to_real(x) + f32_to_real(y));
    endfunction

    function automatic logic [31:0] fsub(input logic [31:0] x, input logic [31:0] y);
        return real_to_f32(f32_to_real(x) - f32_to_real(y));
    endfunction

    function automatic logic [31:0] fdiv(input logic [31:0] x, input logic [31:0] y);
        return real_to_f32(f32_to_real(x) / f32_to_real(y));
    endfunction

    function automatic inverse_t inverse_predict(input logic [287:0] mat);
        logic [31:0] a [9];
        logic [31:0] det;
        logic [31:0] cof;
        inverse_t    res;
        // Cofactor C = a[p]*a[q] - a[r]*a[s], row-major order.
        int p_idx [9] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
        int q_idx [9] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
        int r_idx [9] = '{7, 1, 2, 8, 2, 0, 6, 0, 1};
        int s_idx [9] = '{5, 8, 4, 3, 6, 5, 4, 7, 3};
        for (int i = 0; i < 9; i++)
            a[i] = mat[32*i +: 32];
        det = fmul(fmul(a[0], a[4]), a[8]);
        det = fadd(det, fmul(fmul(a[1], a[5]), a[6]));
        det = fadd(det, fmul(fmul(a[2], a[3]), a[7]));
        det = fsub(det, fmul(fmul(a[0], a[5]), a[7]));
        det = fsub(det, fmul(fmul(a[1], a[3]), a[8]));
        det = fsub(det, fmul(fmul(a[2], a[4]), a[6]));
        if (det[30:0] == 0) begin
            res.inv      = mat;
            res.singular = 1'b1;
            return res;
        end
        for (int i = 0; i < 9; i++) begin
            cof = fsub(fmul(a[p_idx[i]], a[q_idx[i]]), fmul(a[r_idx[i]], a[s_idx[i]]));
            res.inv[32*i +: 32] = fdiv(cof, det);
        end
        res.singular = 1'b0;
        return res;
    endfunction

    assign pending = inverse_queue.size();

    always @(posedge clk or negedge rst_n) begin
        inverse_t want;
        int       errs;
        if (!rst_n) begin
            fail_count <= 0;
        end
        else begin
            errs = 0;
            if (s_tvalid && s_tready)
                inverse_queue.push_back(inverse_predict(s_tdata));
            if (m_tvalid && m_tready) begin
                if (inverse_queue.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual %h singular %b",
                             $time, m_tdata, m_tuser);
                    errs = errs + 1;
                end
                else begin
                    want = inverse_queue.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (m_tdata[32*i +: 32] !== want.inv[32*i +: 32]) begin
                            $display("%0t: inv entry %0d expected %h actual %h", $time,
                                     i, want.inv[32*i +: 32], m_tdata[32*i +: 32]);
                            errs = errs + 1;
                        end
                    if (m_tuser !== want.singular) begin
                        $display("%0t: singular expected %b actual %b", $time,
                                 want.singular, m_tuser);
                        errs = errs + 1;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

// ----- tb/sv/matrix_inverse_3x3_core_tb.sv -----
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core_tb: stimulus and verdict for the 3x3 inverse core
// Streams directed and random matrices with random gaps and output stalls,
// including a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;   // a_r0c0 .. a_r2c2 from bit 0 up
    logic         m_tvalid;
    logic         m_tready;
    logic [287:0] m_tdata;   // inv_r0c0 .. inv_r2c2 from bit 0 up
    logic         m_tuser;   // singular
    int           fail_count;
    int           pending;
    int           results_seen;
    int           hold_left;
    int           stall_left;
    bit           quiet_out;
    bit           long_hold_done;
    bit           quiet_in;

    matrix_inverse_3x3_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    matrix_inverse_3x3_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20ms;
        $display("matrix_inverse_3x3_core: mismatch");
        $finish;
    end

    // Output side: random stalls per result, quiet stretches without any,
    // and one long hold-off so the pipeline fills and stalls its input.
    always @(posedge clk or negedge rst_n) begin
        logic ready_next;
        if (!rst_n) begin
            m_tready       <= 1'b0;
            results_seen   <= 0;
            hold_left      <= 0;
            stall_left     <= 0;
            quiet_out      <= 1'b0;
            long_hold_done <= 1'b0;
        end
        else begin
            ready_next = 1'b1;
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (results_seen % 64 == 0)
                    quiet_out <= ($urandom_range(0, 2) == 0);
                if (results_seen == 300 && !long_hold_done) begin
                    hold_left      <= 400;
                    long_hold_done <= 1'b1;
                    ready_next     = 1'b0;
                end
                else if (!quiet_out) begin
                    stall_left <= $urandom_range(0, 17);
                end
            end
            else if (hold_left > 0) begin
                hold_left  <= hold_left - 1;
                ready_next = (hold_left == 1);
            end
            else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                ready_next = (stall_left == 1);
            end
            if (m_tvalid && m_tready && !quiet_out && results_seen != 300)
                ready_next = ($urandom_range(0, 1) == 0);
            m_tready <= ready_next;
        end
    end

    function automatic logic [31:0] moderate_value();
        return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
    endfunction

    // Mostly well-scaled entries, with occasional special patterns.
    function automatic logic [31:0] random_entry();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return moderate_value();
        if (pick < 78)
            return $urandom;
        if (pick < 84)
            return {1'($urandom), 8'($urandom_range(0, 40)), 23'($urandom)};
        if (pick < 90)
            return {1'($urandom), 8'($urandom_range(215, 254)), 23'($urandom)};
        if (pick < 93)
            return {1'($urandom), 31'b0};
        if (pick < 95)
            return {1'($urandom), 8'h00, 23'($urandom)};
        if (pick < 97)
            return {1'($urandom), 8'hFF, 23'b0};
        if (pick < 99)
            return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
        return {1'($urandom), 8'd127, 23'd0};
    endfunction

    function automatic logic [287:0] random_matrix();
        logic [287:0] m;
        int           kind;
        for (int i = 0; i < 9; i++)
            m[32*i +: 32] = random_entry();
        kind = $urandom_range(0, 9);
        // Some made singular (a repeated row or zero column), some random.
        if (kind == 0)
            m[64*3 +: 96] = m[0 +: 96];
        else if (kind == 1)
            for (int r = 0; r < 3; r++)
                m[96*r + 32 +: 32] = {1'($urandom), 31'b0};
        else if (kind == 2)
            m = {288{1'b0}} | {$urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom, $urandom};
        return m;
    endfunction

    task automatic send_matrix(input logic [287:0] mat, input bit gaps);
        int gap;
        s_tdata  <= mat;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gap = (gaps && !quiet_in) ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [287:0] uniform_matrix(input logic [31:0] v);
        return {9{v}};
    endfunction

    initial
    begin
        logic [287:0] mat;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        quiet_in = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, scaled and permuted matrices, extremes of the
        // bit patterns, signed zeros, NaN and infinite entries, subnormals.
        mat = '0;
        mat[0 +: 32] = 32'h3F80_0000; mat[128 +: 32] = 32'h3F80_0000;
        mat[256 +: 32] = 32'h3F80_0000;
        send_matrix(mat, 1'b1);
        mat[0 +: 32] = 32'h4000_0000; mat[128 +: 32] = 32'hC040_0000;
        mat[256 +: 32] = 32'h3E80_0000; mat[32 +: 32] = 32'h3F00_0000;
        send_matrix(mat, 1'b0);
        mat = '0;
        mat[32 +: 32] = 32'h3F80_0000; mat[160 +: 32] = 32'h3F80_0000;
        mat[192 +: 32] = 32'h3F80_0000;
        send_matrix(mat, 1'b1);
        send_matrix(uniform_matrix(32'h0000_0000), 1'b1);
        send_matrix(uniform_matrix(32'h8000_0000), 1'b0);
        send_matrix({288{1'b1}}, 1'b1);
        send_matrix(uniform_matrix(32'h7F7F_FFFF), 1'b1);
        send_matrix(uniform_matrix(32'h0000_0001), 1'b0);
        mat = '0;
        mat[0 +: 32] = 32'h7F7F_FFFF; mat[128 +: 32] = 32'h7F7F_FFFF;
        mat[256 +: 32] = 32'h7F7F_FFFF;
        send_matrix(mat, 1'b1);
        mat[0 +: 32] = 32'h0080_0000; mat[128 +: 32] = 32'h0000_0001;
        mat[256 +: 32] = 32'h4000_0000;
        send_matrix(mat, 1'b1);
        mat[0 +: 32] = 32'h7F80_0000; mat[128 +: 32] = 32'h3F80_0000;
        mat[256 +: 32] = 32'h3F80_0000;
        send_matrix(mat, 1'b0);
        mat[0 +: 32] = 32'hFFC1_2345;
        send_matrix(mat, 1'b1);
        send_matrix(uniform_matrix(32'h7FA0_0001), 1'b1);
        send_matrix(uniform_matrix(32'hFF80_0000), 1'b1);
        send_matrix({9{32'h5555_5555}}, 1'b0);
        send_matrix({9{32'hAAAA_AAAA}}, 1'b1);
        mat = '0;
        for (int i = 0; i < 9; i++)
            mat[32*i +: 32] = 32'h3F80_0000 + 32'(i) * 32'h0080_0000;
        send_matrix(mat, 1'b1);
        mat[256 +: 32] = 32'h4120_0001;
        send_matrix(mat, 1'b1);

        // Random part, with one pause that lets every result drain.
        for (int n = 0; n < 1200; n++) begin
            if (n % 50 == 0)
                quiet_in = ($urandom_range(0, 3) == 0);
            if (n == 700) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            send_matrix(random_matrix(), 1'b1);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("matrix_inverse_3x3_core: match");
        else
            $display("matrix_inverse_3x3_core: mismatch");
        $finish;
    end

endmodule
